### src/sble_pkg.sv
// Shared definitions for the sprite base line extractor.
// Holds command codes, register indexes, field widths and default sizes.
// Depends on nothing; the top level and sble_pixel_class import it.
package sble_pkg;

   // Default frame size limits, handed to the top level as parameters.
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   // Field widths of the command, result and register words.
   localparam int FUNC_W     = 2;
   localparam int PIXEL_W    = 32;
   localparam int COORD_W    = 9;
   localparam int MASK_W     = 8;
   localparam int BOTTOM_W   = 9;
   localparam int LIMIT_W    = 10;
   localparam int SIZE_W     = 10;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 10;

   // Command codes carried in req_func.
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_MODE     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REDUCE_SHADOWS = 4'd3;

   // Mask codes.
   localparam logic [MASK_W-1:0] MASK_ON  = 8'hFF;
   localparam logic [MASK_W-1:0] MASK_OFF = 8'h00;

   // Alpha byte of a 32-bit pixel.
   localparam logic [PIXEL_W-1:0] ALPHA_MASK = 32'hFF00_0000;

endpackage

### src/sprite_base_line_extractor.sv
// Sprite base line extractor: column bottom tracking, row limit and base mask queries.
// Uses sble_pkg, sble_col_ram (column bottom store) and sble_pixel_class.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------------
//  command   start, busy, req_func, req_pixel,       taken when start && !busy
//            req_query_x, req_query_y
//  result    rsp_valid, rsp_mask_value,              one-cycle strobe, no back-pressure
//            rsp_column_bottom, rsp_base_limit
//  config    csr_valid, csr_ready, csr_index,        written when csr_valid && csr_ready
//            csr_wdata
//
// A pixel load is a read then a conditional write of the column RAM at the load column.
// A query with a held limit reads its column and both neighbours before its result strobe;
// a stale limit first adds the height/3 product, the base limit and the reissued read, and
// with shadow reduction a scan that reads every column once through the RAM port.
// Reset and the clear command run a clearing pass over all MAX_WIDTH columns with busy high;
// configuration writes are still taken then. The receiver cannot stall the result word.
module sprite_base_line_extractor #(
   parameter int MAX_WIDTH  = sble_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sble_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [sble_pkg::FUNC_W-1:0]     req_func,
   input  logic [sble_pkg::PIXEL_W-1:0]    req_pixel,
   input  logic [sble_pkg::COORD_W-1:0]    req_query_x,
   input  logic [sble_pkg::COORD_W-1:0]    req_query_y,
   output logic                            rsp_valid,
   output logic [sble_pkg::MASK_W-1:0]     rsp_mask_value,
   output logic [sble_pkg::BOTTOM_W-1:0]   rsp_column_bottom,
   output logic [sble_pkg::LIMIT_W-1:0]    rsp_base_limit,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sble_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sble_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sble_pkg::*;

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int LW    = (CW > HW) ? CW : HW;
   localparam int KW    = ((LW > SIZE_W) ? LW : SIZE_W) + 1;
   localparam int SH    = HW + 2;
   localparam int RECIP = (2 ** SH + 2) / 3;
   localparam int PW    = HW + SH;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_WR,
      ST_LIM_MUL,
      ST_LIM_BASE,
      ST_SCAN,
      ST_SCAN_END,
      ST_Q_ISSUE,
      ST_Q_LEFT,
      ST_Q_RIGHT,
      ST_Q_EVAL
   } state_type;

   state_type             state_ff, state_in;
   logic [SIZE_W-1:0]     frame_width_ff, frame_width_in;
   logic [SIZE_W-1:0]     frame_height_ff, frame_height_in;
   logic                  pixel_mode_ff, pixel_mode_in;
   logic                  reduce_ff, reduce_in;
   logic [XW-1:0]         clr_cnt_ff, clr_cnt_in;
   logic [XW-1:0]         load_col_ff, load_col_in;
   logic [HW-1:0]         load_row_ff, load_row_in;
   logic [HW-1:0]         limit_ff, limit_in;
   logic                  limit_ready_ff, limit_ready_in;
   logic [XW-1:0]         ld_addr_ff, ld_addr_in;
   logic [YW-1:0]         ld_row_ff, ld_row_in;
   logic                  ld_counted_ff, ld_counted_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [CW-1:0]         scan_cnt_ff, scan_cnt_in;
   logic [XW-1:0]         scan_px_ff, scan_px_in;
   logic                  scan_pv_ff, scan_pv_in;
   logic                  found_ff, found_in;
   logic [XW-1:0]         left_ff, left_in;
   logic [XW-1:0]         right_ff, right_in;
   logic [COORD_W-1:0]    q_x_ff, q_x_in;
   logic [COORD_W-1:0]    q_y_ff, q_y_in;
   logic [YW-1:0]         b_ff, b_in;
   logic [YW-1:0]         nbl_ff, nbl_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic [BOTTOM_W-1:0]   rsp_bottom_ff, rsp_bottom_in;
   logic [LIMIT_W-1:0]    rsp_limit_ff, rsp_limit_in;

   logic [CW-1:0]         w_eff;
   logic [HW-1:0]         h_eff;
   logic [XW-1:0]         col_eff;
   logic [CW-1:0]         next_col;
   logic                  counted;
   logic                  wr_en;
   logic [XW-1:0]         wr_addr;
   logic [YW-1:0]         wr_data;
   logic [XW-1:0]         rd_addr;
   logic [YW-1:0]         rd_data;
   logic [CW-1:0]         span;
   logic [CW-1:0]         span4;
   logic [LW-1:0]         slim_lim;
   logic                  slim_raise;
   logic [KW-1:0]         qxk, qyk, bk, lk, lnk, rnk, wk, hk;
   logic                  in_x, in_frame, left_fill, right_fill;
   logic [MASK_W-1:0]     mask;

   sble_col_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (XW),
      .DW    (YW)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sble_pixel_class u_pixel_class (
      .pixel          (req_pixel),
      .pixel_mode     (pixel_mode_ff),
      .reduce_shadows (reduce_ff),
      .counted        (counted)
   );

   // Sizes of zero act as one; sizes above the maximum are held at the maximum.
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = CW'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(frame_height_ff);
      end
   end

   assign col_eff  = (LW'(load_col_ff) >= LW'(w_eff)) ? '0 : load_col_ff;
   assign next_col = CW'(col_eff) + 1'b1;

   // Slim sprite correction: the span of drawn columns bounds how far the limit may drop.
   assign span       = found_ff ? CW'(right_ff - left_ff) : w_eff;
   assign span4      = (span < CW'(4)) ? CW'(4) : span;
   assign slim_lim   = LW'(h_eff) - LW'(span4);
   assign slim_raise = (LW'(h_eff) > LW'(span4)) && (slim_lim > LW'(limit_ff));

   // Mask evaluation; the right neighbour's bottom arrives on the read port in Q_EVAL.
   assign qxk        = KW'(q_x_ff);
   assign qyk        = KW'(q_y_ff);
   assign bk         = KW'(b_ff);
   assign lk         = KW'(limit_ff);
   assign lnk        = KW'(nbl_ff);
   assign rnk        = KW'(rd_data);
   assign wk         = KW'(w_eff);
   assign hk         = KW'(h_eff);
   assign in_x       = qxk < wk;
   assign in_frame   = in_x && (qyk < hk);
   assign left_fill  = (qxk != '0) && (lnk > lk) && (bk > lnk + 1'b1) &&
                       (qyk >= lnk) && (qyk < bk);
   assign right_fill = (qxk + 1'b1 < wk) && (rnk > lk) && (bk > rnk + 1'b1) &&
                       (qyk >= rnk) && (qyk < bk);
   assign mask       = (in_frame && (bk > lk) && ((qyk == bk) || left_fill || right_fill)) ?
                       MASK_ON : MASK_OFF;

   always_comb begin
      state_in        = state_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      pixel_mode_in   = pixel_mode_ff;
      reduce_in       = reduce_ff;
      clr_cnt_in      = clr_cnt_ff;
      load_col_in     = load_col_ff;
      load_row_in     = load_row_ff;
      limit_in        = limit_ff;
      limit_ready_in  = limit_ready_ff;
      ld_addr_in      = ld_addr_ff;
      ld_row_in       = ld_row_ff;
      ld_counted_in   = ld_counted_ff;
      prod_in         = prod_ff;
      scan_cnt_in     = scan_cnt_ff;
      scan_px_in      = scan_px_ff;
      scan_pv_in      = scan_pv_ff;
      found_in        = found_ff;
      left_in         = left_ff;
      right_in        = right_ff;
      q_x_in          = q_x_ff;
      q_y_in          = q_y_ff;
      b_in            = b_ff;
      nbl_in          = nbl_ff;
      rsp_valid_in    = 1'b0;
      rsp_mask_in     = rsp_mask_ff;
      rsp_bottom_in   = rsp_bottom_ff;
      rsp_limit_in    = rsp_limit_ff;
      wr_en           = 1'b0;
      wr_addr         = clr_cnt_ff;
      wr_data         = '0;
      rd_addr         = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (clr_cnt_ff == XW'(MAX_WIDTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_func)
                  FUNC_LOAD: begin
                     limit_ready_in = 1'b0;
                     // Pixels past the last row are dropped.
                     if (LW'(load_row_ff) < LW'(h_eff)) begin
                        rd_addr       = col_eff;
                        ld_addr_in    = col_eff;
                        ld_row_in     = YW'(load_row_ff);
                        ld_counted_in = counted;
                        if (LW'(next_col) >= LW'(w_eff)) begin
                           load_col_in = '0;
                           load_row_in = load_row_ff + 1'b1;
                        end else begin
                           load_col_in = XW'(next_col);
                        end
                        state_in = ST_LOAD_WR;
                     end
                  end
                  FUNC_QUERY: begin
                     q_x_in = req_query_x;
                     q_y_in = req_query_y;
                     if (limit_ready_ff) begin
                        rd_addr  = XW'(req_query_x);
                        state_in = ST_Q_LEFT;
                     end else begin
                        state_in = ST_LIM_MUL;
                     end
                  end
                  FUNC_CLEAR: begin
                     load_col_in    = '0;
                     load_row_in    = '0;
                     limit_ready_in = 1'b0;
                     clr_cnt_in     = '0;
                     state_in       = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD_WR: begin
            wr_en    = ld_counted_ff && (rd_data < ld_row_ff);
            wr_addr  = ld_addr_ff;
            wr_data  = ld_row_ff;
            state_in = ST_IDLE;
         end
         ST_LIM_MUL: begin
            // Height divided by three through a reciprocal that is exact over the range.
            prod_in  = PW'(h_eff) * PW'(RECIP);
            state_in = ST_LIM_BASE;
         end
         ST_LIM_BASE: begin
            limit_in = h_eff - HW'(prod_ff >> SH);
            if (reduce_ff) begin
               scan_cnt_in = '0;
               scan_pv_in  = 1'b0;
               found_in    = 1'b0;
               left_in     = '0;
               right_in    = XW'(w_eff - 1'b1);
               state_in    = ST_SCAN;
            end else begin
               limit_ready_in = 1'b1;
               state_in       = ST_Q_ISSUE;
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff < w_eff) begin
               rd_addr     = XW'(scan_cnt_ff);
               scan_px_in  = XW'(scan_cnt_ff);
               scan_pv_in  = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else begin
               scan_pv_in = 1'b0;
               if (!scan_pv_ff) begin
                  state_in = ST_SCAN_END;
               end
            end
            // The first drawn column sets the left edge, each later one moves the right edge.
            if (scan_pv_ff && (HW'(rd_data) > limit_ff)) begin
               if (!found_ff) begin
                  found_in = 1'b1;
                  left_in  = scan_px_ff;
               end else begin
                  right_in = scan_px_ff;
               end
            end
         end
         ST_SCAN_END: begin
            if (slim_raise) begin
               limit_in = HW'(slim_lim);
            end
            limit_ready_in = 1'b1;
            state_in       = ST_Q_ISSUE;
         end
         ST_Q_ISSUE: begin
            rd_addr  = XW'(q_x_ff);
            state_in = ST_Q_LEFT;
         end
         ST_Q_LEFT: begin
            b_in     = rd_data;
            rd_addr  = XW'(q_x_ff - 1'b1);
            state_in = ST_Q_RIGHT;
         end
         ST_Q_RIGHT: begin
            nbl_in   = rd_data;
            rd_addr  = XW'({1'b0, q_x_ff} + 1'b1);
            state_in = ST_Q_EVAL;
         end
         ST_Q_EVAL: begin
            rsp_valid_in  = 1'b1;
            rsp_mask_in   = mask;
            rsp_bottom_in = in_x ? BOTTOM_W'(b_ff) : '0;
            rsp_limit_in  = LIMIT_W'(limit_ff);
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_in = csr_wdata[SIZE_W-1:0];
               limit_ready_in = 1'b0;
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata[SIZE_W-1:0];
               limit_ready_in  = 1'b0;
            end
            CSR_PIXEL_MODE: begin
               pixel_mode_in  = csr_wdata[0];
               limit_ready_in = 1'b0;
            end
            CSR_REDUCE_SHADOWS: begin
               reduce_in      = csr_wdata[0];
               limit_ready_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         frame_width_ff  <= SIZE_W'(1);
         frame_height_ff <= SIZE_W'(1);
         pixel_mode_ff   <= 1'b0;
         reduce_ff       <= 1'b0;
         clr_cnt_ff      <= '0;
         load_col_ff     <= '0;
         load_row_ff     <= '0;
         limit_ff        <= '0;
         limit_ready_ff  <= 1'b0;
         scan_pv_ff      <= 1'b0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         pixel_mode_ff   <= pixel_mode_in;
         reduce_ff       <= reduce_in;
         clr_cnt_ff      <= clr_cnt_in;
         load_col_ff     <= load_col_in;
         load_row_ff     <= load_row_in;
         limit_ff        <= limit_in;
         limit_ready_ff  <= limit_ready_in;
         scan_pv_ff      <= scan_pv_in;
         found_ff        <= found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      ld_addr_ff    <= ld_addr_in;
      ld_row_ff     <= ld_row_in;
      ld_counted_ff <= ld_counted_in;
      prod_ff       <= prod_in;
      scan_cnt_ff   <= scan_cnt_in;
      scan_px_ff    <= scan_px_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      q_x_ff        <= q_x_in;
      q_y_ff        <= q_y_in;
      b_ff          <= b_in;
      nbl_ff        <= nbl_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_bottom_ff <= rsp_bottom_in;
      rsp_limit_ff  <= rsp_limit_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mask_value    = rsp_mask_ff;
   assign rsp_column_bottom = rsp_bottom_ff;
   assign rsp_base_limit    = rsp_limit_ff;

`ifndef SYNTHESIS
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_rsp_from_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_Q_EVAL)
      else $error("result word issued outside the query evaluation step");

   a_mask_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mask_value == MASK_ON || rsp_mask_value == MASK_OFF))
      else $error("mask value is neither on nor off");

   a_reset_busy: assert property (@(posedge clock)
      reset |=> busy)
      else $error("block not busy with the clearing pass after reset");
`endif

endmodule

### src/sble_pixel_class.sv
// Pixel classifier: decides whether a loaded pixel counts towards a column bottom.
// Palette mode tests the low byte against the dark index list; 32-bit mode tests alpha.
// Depends on sble_pkg.
module sble_pixel_class (
   input  logic [sble_pkg::PIXEL_W-1:0] pixel,
   input  logic                         pixel_mode,
   input  logic                         reduce_shadows,
   output logic                         counted
);
   import sble_pkg::*;

   localparam int DARK_N = 17;
   localparam logic [7:0] DARK_LIST [DARK_N] = '{
      8'h00, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h1F, 8'h2F, 8'h35, 8'h36, 8'h37,
      8'h44, 8'h63, 8'h64, 8'hCA, 8'hCF, 8'hE3, 8'hE4
   };

   logic dark_hit;

   // Index zero is always transparent; the rest of the list only with shadow reduction.
   always_comb begin
      dark_hit = 1'b0;
      for (int i = 0; i < DARK_N; i++) begin
         if ((i == 0 || reduce_shadows) && pixel[7:0] == DARK_LIST[i]) begin
            dark_hit = 1'b1;
         end
      end
   end

   assign counted = pixel_mode ? ((pixel & ALPHA_MASK) == '0) : !dark_hit;

endmodule

### src/sble_col_ram.sv
// Column bottom store: single write port, single read port, registered read data.
// Plain synchronous RAM.
// Depends on nothing.
module sble_col_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9,
   parameter int DW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
